// ===== design/mbm_pkg.sv =====
// Package for the Modbus RTU master frame engine: payload structs, codes,
// queue entry type and the CRC-16/MODBUS byte update. No dependencies.
`default_nettype none
package mbm_pkg;

    localparam int MAX_FRAME       = 256;
    localparam int MAX_WRITE_WORDS = 123;
    localparam int RX_CAP          = (MAX_FRAME < 511) ? MAX_FRAME : 511;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [3:0]  RETRY_RESET = 4'd10;

    localparam logic [1:0] CMD_REQ  = 2'd0;
    localparam logic [1:0] CMD_WORD = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;

    localparam logic [2:0] F_RD_COILS = 3'd0;
    localparam logic [2:0] F_RD_COIL  = 3'd1;
    localparam logic [2:0] F_WR_COIL  = 3'd2;
    localparam logic [2:0] F_RD_HOLD  = 3'd3;
    localparam logic [2:0] F_RD_INP   = 3'd4;
    localparam logic [2:0] F_WR_REG   = 3'd5;
    localparam logic [2:0] F_WR_MULTI = 3'd6;
    localparam logic [2:0] F_NONE     = 3'd7;

    localparam logic [1:0] K_TX     = 2'd0;
    localparam logic [1:0] K_DATA   = 2'd1;
    localparam logic [1:0] K_STATUS = 2'd2;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SHORT  = 3'd1;
    localparam logic [2:0] ST_CRC    = 3'd2;
    localparam logic [2:0] ST_HEADER = 3'd3;
    localparam logic [2:0] ST_BCOUNT = 3'd4;
    localparam logic [2:0] ST_ADDR   = 3'd5;
    localparam logic [2:0] ST_VALUE  = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [2:0]  func_sel;
        logic [7:0]  slave;
        logic [15:0] start_addr;
        logic [15:0] count_or_value;
        logic [15:0] load_word;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] rx_data;
        logic [2:0]  status;
        logic [3:0]  attempt;
        logic        give_up;
        logic        coil_on;
        logic        last;
    } out_item_t;

    // Classified work entry passed from front to back.
    typedef enum logic [1:0] {
        OP_REQ  = 2'd0,
        OP_WORD = 2'd1,
        OP_RX   = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  func_sel;
        logic [7:0]  slave;
        logic [15:0] start_addr;
        logic [15:0] count;
        logic [15:0] load_word;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } work_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_EMIT = 2'd1,
        BK_STAT = 2'd2
    } bk_state_t;

    function automatic logic [7:0] func_code(input logic [2:0] f);
        logic [7:0] c;
        case (f)
            F_RD_COILS: c = 8'h01;
            F_RD_COIL:  c = 8'h01;
            F_WR_COIL:  c = 8'h05;
            F_RD_HOLD:  c = 8'h03;
            F_RD_INP:   c = 8'h04;
            F_WR_REG:   c = 8'h06;
            F_WR_MULTI: c = 8'h10;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== design/modbus_rtu_master_frame_engine.sv =====
// Top level of the Modbus RTU master frame engine: configuration register,
// front end, back end. Depends on mbm_pkg, mbm_front and mbm_back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    mbm_pkg::in_item_t
//   m_        out        m_valid / m_ready    mbm_pkg::out_item_t
//   cfg_      in         cfg_valid/cfg_ready  retry_limit, 4 bits
//
// A request transfer is taken while the back end is idle; its frame bytes then
// leave, the CRC last unless data words follow. The single output register of
// the back end lets one byte leave per cycle while m_ready holds. A data word
// adds two bytes, and the CRC after the last word. A received byte can give a
// data result and, on the last byte, the status. Reset is synchronous and
// active low and restores the retry limit to ten. A two-entry queue lets the
// front accept transfers while the back end is stalled on m_ready.
`default_nettype none
module modbus_rtu_master_frame_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mbm_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mbm_pkg::out_item_t      m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_data
);
    import mbm_pkg::*;

    logic [3:0] retry_limit_reg;
    logic       q_valid, q_ready;
    work_t      q_data;

    // The register is always writable.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RETRY_RESET;
        end else if (cfg_valid) begin
            retry_limit_reg <= cfg_data;
        end
    end

    mbm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    mbm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .retry_limit (retry_limit_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_data      (q_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );
endmodule
`default_nettype wire

// ===== design/mbm_front.sv =====
// Front end: accepts input items, drops ones that cause no result and
// normalises request counts. Depends on mbm_pkg.
`default_nettype none
module mbm_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mbm_pkg::in_item_t s_data,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output mbm_pkg::work_t        q_data
);
    import mbm_pkg::*;

    logic   keep;
    work_t  w;

    // Drops happen at acceptance; data words are filtered in the back end
    // because whether one is awaited depends on earlier work.
    always_comb begin
        w = '0;
        w.func_sel   = s_data.func_sel;
        w.slave      = s_data.slave;
        w.start_addr = s_data.start_addr;
        w.count      = s_data.count_or_value;
        w.load_word  = s_data.load_word;
        w.rx_byte    = s_data.rx_byte;
        w.rx_last    = s_data.rx_last;
        keep = 1'b1;
        case (s_data.cmd)
            CMD_REQ: begin
                w.op = OP_REQ;
                if (s_data.func_sel == F_NONE) begin
                    keep = 1'b0;
                end
                if (s_data.func_sel == F_RD_COIL) begin
                    w.count = 16'd1;
                end
                if (s_data.func_sel == F_WR_MULTI &&
                    s_data.count_or_value > 16'(MAX_WRITE_WORDS)) begin
                    w.count = 16'(MAX_WRITE_WORDS);
                end
            end
            CMD_WORD: w.op = OP_WORD;
            CMD_RX:   w.op = OP_RX;
            default: begin
                w.op = OP_RX;
                keep = 1'b0;
            end
        endcase
    end

    // Two-entry queue.
    work_t     mem_reg [2];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic      push, pop;

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= w;
        end
    end
endmodule
`default_nettype wire

// ===== design/mbm_back.sv =====
// Back end: holds the request and response state, emits frame bytes,
// read data and status through an output register. Depends on mbm_pkg.
`default_nettype none
module mbm_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [3:0]        retry_limit,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire mbm_pkg::work_t    q_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mbm_pkg::out_item_t     m_data
);
    import mbm_pkg::*;

    bk_state_t   state_reg, state_next;
    logic [15:0] tx_crc_reg, tx_crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [8:0]  rx_count_reg, rx_count_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic [2:0]  req_func_reg, req_func_next;
    logic [7:0]  req_slave_reg, req_slave_next;
    logic [15:0] req_addr_reg, req_addr_next;
    logic [15:0] req_count_reg, req_count_next;
    logic [6:0]  words_left_reg, words_left_next;
    logic [2:0]  first_error_reg, first_error_next;
    logic [3:0]  fail_count_reg, fail_count_next;
    logic [15:0] last_two_reg, last_two_next;
    // Byte sequence being transmitted: up to 9 bytes, index and count.
    logic [7:0]  seq_reg [9];
    logic [7:0]  seq_next [9];
    logic [3:0]  seq_idx_reg, seq_idx_next;
    logic [3:0]  seq_len_reg, seq_len_next;
    logic        seq_crc_reg, seq_crc_next;
    logic        out_v_reg, out_v_next;
    out_item_t   out_reg, out_next;

    logic        out_free;
    logic        take;
    logic [15:0] crc_step;

    assign out_free = !out_v_reg || m_ready;
    assign m_valid  = out_v_reg;
    assign m_data   = out_reg;
    assign q_ready  = (state_reg == BK_IDLE) && out_free;
    assign take     = q_valid && q_ready;
    assign crc_step = crc_feed(tx_crc_reg, seq_reg[seq_idx_reg]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (take && seq_len_next != 4'd0)
                         state_next = (q_data.op == OP_RX) ? BK_STAT : BK_EMIT;
            BK_EMIT: if (out_free && seq_idx_reg + 4'd1 >= seq_len_reg)
                         state_next = BK_IDLE;
            BK_STAT: if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        logic [15:0] cb;
        logic [16:0] exp_bc;
        logic [8:0]  p;
        logic [7:0]  b;
        logic [7:0]  ex;
        logic        chk;
        logic [2:0]  ecode;
        logic [3:0]  minlen;
        logic [2:0]  st;
        logic [3:0]  fc;
        logic        give;
        logic [15:0] pm3;
        tx_crc_next      = tx_crc_reg;
        rx_crc_next      = rx_crc_reg;
        rx_count_next    = rx_count_reg;
        held_byte_next   = held_byte_reg;
        req_func_next    = req_func_reg;
        req_slave_next   = req_slave_reg;
        req_addr_next    = req_addr_reg;
        req_count_next   = req_count_reg;
        words_left_next  = words_left_reg;
        first_error_next = first_error_reg;
        fail_count_next  = fail_count_reg;
        last_two_next    = last_two_reg;
        seq_next         = seq_reg;
        seq_idx_next     = seq_idx_reg;
        seq_len_next     = 4'd0;
        seq_crc_next     = seq_crc_reg;
        out_v_next       = out_v_reg && !m_ready;
        out_next         = out_reg;
        cb = 16'((17'(req_count_reg) + 17'd7) >> 3);
        exp_bc = 17'd0; p = 9'd0; b = 8'd0; ex = 8'd0; chk = 1'b0;
        ecode = ST_OK; minlen = 4'd6; st = ST_OK; fc = 4'd0; give = 1'b0;
        pm3 = 16'd0;

        if (state_reg == BK_EMIT && out_free) begin
            // Normal byte or one of the two trailing CRC bytes.
            out_v_next = 1'b1;
            out_next = '0;
            out_next.kind = K_TX;
            if (seq_crc_reg && seq_idx_reg + 4'd2 == seq_len_reg) begin
                out_next.tx_byte = tx_crc_reg[7:0];
            end else if (seq_crc_reg && seq_idx_reg + 4'd1 == seq_len_reg) begin
                out_next.tx_byte = tx_crc_reg[15:8];
            end else begin
                out_next.tx_byte = seq_reg[seq_idx_reg];
                tx_crc_next = crc_step;
            end
            out_next.last = (seq_idx_reg + 4'd1 == seq_len_reg);
            seq_idx_next = seq_idx_reg + 4'd1;
        end else if (take) begin
            case (q_data.op)
                OP_REQ: begin
                    if (q_data.func_sel != req_func_reg ||
                        q_data.slave != req_slave_reg ||
                        q_data.start_addr != req_addr_reg ||
                        q_data.count != req_count_reg) begin
                        fail_count_next = 4'd0;
                    end
                    req_func_next  = q_data.func_sel;
                    req_slave_next = q_data.slave;
                    req_addr_next  = q_data.start_addr;
                    req_count_next = q_data.count;
                    rx_crc_next = CRC_INIT; rx_count_next = 9'd0;
                    last_two_next = 16'd0; held_byte_next = 8'd0;
                    first_error_next = ST_OK;
                    tx_crc_next = CRC_INIT;
                    seq_next[0] = q_data.slave;
                    seq_next[1] = func_code(q_data.func_sel);
                    seq_next[2] = q_data.start_addr[15:8];
                    seq_next[3] = q_data.start_addr[7:0];
                    if (q_data.func_sel == F_WR_COIL) begin
                        seq_next[4] = (q_data.count != 16'd0) ? 8'hFF : 8'h00;
                        seq_next[5] = 8'h00;
                    end else begin
                        seq_next[4] = q_data.count[15:8];
                        seq_next[5] = q_data.count[7:0];
                    end
                    seq_idx_next = 4'd0;
                    if (q_data.func_sel == F_WR_MULTI) begin
                        seq_next[6] = {q_data.count[6:0], 1'b0};
                        words_left_next = q_data.count[6:0];
                        seq_crc_next = (q_data.count[6:0] == 7'd0);
                        seq_len_next = seq_crc_next ? 4'd9 : 4'd7;
                    end else begin
                        words_left_next = 7'd0;
                        seq_crc_next = 1'b1;
                        seq_len_next = 4'd8;
                    end
                end
                OP_WORD: begin
                    if (words_left_reg != 7'd0) begin
                        seq_next[0] = q_data.load_word[15:8];
                        seq_next[1] = q_data.load_word[7:0];
                        words_left_next = words_left_reg - 7'd1;
                        seq_idx_next = 4'd0;
                        seq_crc_next = (words_left_reg == 7'd1);
                        seq_len_next = seq_crc_next ? 4'd4 : 4'd2;
                    end
                end
                default: begin
                    // Received byte: checks, data and, on the last byte, status.
                    b = q_data.rx_byte;
                    out_next = '0;
                    out_next.kind = K_DATA;
                    if (rx_count_reg < 9'(RX_CAP)) begin
                        p = rx_count_reg;
                        pm3 = 16'(p) - 16'd3;
                        if (p >= 9'd2) rx_crc_next = crc_feed(rx_crc_reg, last_two_reg[15:8]);
                        last_two_next = {last_two_reg[7:0], b};
                        if (req_func_reg == F_RD_COILS || req_func_reg == F_RD_COIL ||
                            req_func_reg == F_RD_HOLD || req_func_reg == F_RD_INP) begin
                            exp_bc = (req_func_reg == F_RD_COILS) ? {1'b0, cb} :
                                     (req_func_reg == F_RD_COIL) ? 17'd1 :
                                     {req_count_reg, 1'b0};
                            if (p == 9'd2 && {9'h000, b} != exp_bc) ecode = ST_BCOUNT;
                        end else begin
                            chk = 1'b1;
                            case (p)
                                9'd0: begin ex = req_slave_reg; ecode = ST_HEADER; end
                                9'd1: begin ex = func_code(req_func_reg);
                                            ecode = ST_HEADER; end
                                9'd2: begin ex = req_addr_reg[15:8]; ecode = ST_ADDR; end
                                9'd3: begin ex = req_addr_reg[7:0]; ecode = ST_ADDR; end
                                9'd4: begin
                                    ex = (req_func_reg == F_WR_COIL) ?
                                         ((req_count_reg != 16'd0) ? 8'hFF : 8'h00) :
                                         req_count_reg[15:8];
                                    ecode = ST_VALUE;
                                end
                                9'd5: begin
                                    ex = (req_func_reg == F_WR_COIL) ? 8'h00 :
                                         req_count_reg[7:0];
                                    ecode = ST_VALUE;
                                end
                                default: chk = 1'b0;
                            endcase
                            if (!chk || b == ex) ecode = ST_OK;
                        end
                        if (first_error_reg == ST_OK) first_error_next = ecode;
                        case (req_func_reg)
                            F_RD_COILS: if (p >= 9'd3 && pm3 < cb) begin
                                out_v_next = 1'b1;
                                out_next.rx_data = {8'h00, b};
                            end
                            F_RD_COIL: if (p == 9'd3) begin
                                held_byte_next = b;
                                out_v_next = 1'b1;
                                out_next.rx_data = {8'h00, b};
                                out_next.coil_on = (b != 8'h00);
                            end
                            F_RD_HOLD, F_RD_INP: begin
                                if (p >= 9'd3 && 17'(pm3) < {req_count_reg, 1'b0}) begin
                                    if (!pm3[0]) held_byte_next = b;
                                    else begin
                                        out_v_next = 1'b1;
                                        out_next.rx_data = {held_byte_reg, b};
                                    end
                                end
                            end
                            default: ;
                        endcase
                        rx_count_next = p + 9'd1;
                    end
                    out_next.last = !q_data.rx_last;
                    if (q_data.rx_last) begin
                        minlen = (req_func_reg == F_WR_COIL || req_func_reg == F_RD_HOLD ||
                                  req_func_reg == F_RD_INP || req_func_reg == F_WR_REG) ?
                                 4'd8 : 4'd6;
                        if (rx_count_next < 9'(minlen)) st = ST_SHORT;
                        else if (rx_crc_next[7:0] != last_two_next[15:8] ||
                                 rx_crc_next[15:8] != last_two_next[7:0]) st = ST_CRC;
                        else st = first_error_next;
                        fc = fail_count_reg;
                        if (st != ST_OK) begin
                            if (fc != 4'd15) fc = fc + 4'd1;
                            give = (fc >= retry_limit);
                        end
                        // The status waits in the sequence slot while data, if any, goes first.
                        seq_next[0] = {1'b0, st, fc};
                        seq_next[1] = {6'd0, give,
                                       (req_func_reg == F_RD_COIL && st == ST_OK &&
                                        held_byte_next != 8'h00)};
                        fail_count_next = (st == ST_OK || give) ? 4'd0 : fc;
                        rx_crc_next = CRC_INIT; rx_count_next = 9'd0;
                        last_two_next = 16'd0; held_byte_next = 8'd0;
                        first_error_next = ST_OK;
                        if (out_v_next && !(out_v_reg && !m_ready)) begin
                            // Data result this cycle; status goes next.
                            seq_len_next = 4'd1;
                        end else begin
                            out_v_next = 1'b1;
                            out_next = '0;
                            out_next.kind = K_STATUS;
                            out_next.status = st;
                            out_next.attempt = fc;
                            out_next.give_up = give;
                            out_next.coil_on = seq_next[1][0];
                            out_next.last = 1'b1;
                        end
                    end
                end
            endcase
        end
        // Pending status output after a data word on the final byte.
        if (state_reg == BK_STAT && out_free) begin
            out_v_next = 1'b1;
            out_next = '0;
            out_next.kind = K_STATUS;
            out_next.status = seq_reg[0][6:4];
            out_next.attempt = seq_reg[0][3:0];
            out_next.give_up = seq_reg[1][1];
            out_next.coil_on = seq_reg[1][0];
            out_next.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= BK_IDLE;
            tx_crc_reg      <= CRC_INIT;
            rx_crc_reg      <= CRC_INIT;
            rx_count_reg    <= 9'd0;
            held_byte_reg   <= 8'd0;
            req_func_reg    <= F_RD_COILS;
            req_slave_reg   <= 8'd0;
            req_addr_reg    <= 16'd0;
            req_count_reg   <= 16'd0;
            words_left_reg  <= 7'd0;
            first_error_reg <= ST_OK;
            fail_count_reg  <= 4'd0;
            last_two_reg    <= 16'd0;
            seq_idx_reg     <= 4'd0;
            seq_len_reg     <= 4'd0;
            seq_crc_reg     <= 1'b0;
            out_v_reg       <= 1'b0;
        end else begin
            state_reg       <= state_next;
            tx_crc_reg      <= tx_crc_next;
            rx_crc_reg      <= rx_crc_next;
            rx_count_reg    <= rx_count_next;
            held_byte_reg   <= held_byte_next;
            req_func_reg    <= req_func_next;
            req_slave_reg   <= req_slave_next;
            req_addr_reg    <= req_addr_next;
            req_count_reg   <= req_count_next;
            words_left_reg  <= words_left_next;
            first_error_reg <= first_error_next;
            fail_count_reg  <= fail_count_next;
            last_two_reg    <= last_two_next;
            seq_idx_reg     <= seq_idx_next;
            if (take) seq_len_reg <= seq_len_next;
            seq_crc_reg     <= seq_crc_next;
            out_v_reg       <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        seq_reg <= seq_next;
    end
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the Modbus RTU master frame engine.
// Depends on mbm_pkg and modbus_rtu_master_frame_engine; no other files.
`timescale 1ns / 100ps

module tb_top;
    import mbm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD = 400;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data = 4'd0;

    modbus_rtu_master_frame_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // The engine as the testbench sees it: retry limit, request held for
    // echo checks, and the progress through the current response frame.
    logic [3:0]  m_limit;
    logic [15:0] m_tx_crc, m_rx_crc, m_last_two;
    int          m_rx_count;
    logic [7:0]  m_held, m_slave;
    logic [2:0]  m_func, m_first_err;
    logic [15:0] m_addr, m_count;
    logic [6:0]  m_words_left;
    logic [3:0]  m_fails;

    out_item_t   step_results[$];
    out_item_t   results_due[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycles = 0;
    int          burst_left = 0;

    // Receiver stall control; the long hold-off is asked for by the stimulus.
    int          hold_asked = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          stall_style = 0;
    int          stall_span = 0;

    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] code_of(logic [2:0] f);
        case (f)
            F_RD_COILS, F_RD_COIL: return 8'h01;
            F_WR_COIL:             return 8'h05;
            F_RD_HOLD:             return 8'h03;
            F_RD_INP:              return 8'h04;
            F_WR_REG:              return 8'h06;
            default:               return 8'h10;
        endcase
    endfunction

    function automatic int coil_bytes_due();
        return (int'(m_count) + 7) / 8;
    endfunction

    function automatic void emit(logic [1:0] kind, logic [7:0] tx, logic [15:0] data,
                                 logic [2:0] st, logic [3:0] att, logic give, logic coil);
        out_item_t r;
        r = '0;
        r.kind = kind;
        r.tx_byte = tx;
        r.rx_data = data;
        r.status = st;
        r.attempt = att;
        r.give_up = give;
        r.coil_on = coil;
        step_results.push_back(r);
    endfunction

    function automatic void emit_tx(logic [7:0] b);
        m_tx_crc = crc_byte(m_tx_crc, b);
        emit(K_TX, b, 16'h0, ST_OK, 4'd0, 1'b0, 1'b0);
    endfunction

    function automatic void emit_tx_crc();
        emit(K_TX, m_tx_crc[7:0], 16'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        emit(K_TX, m_tx_crc[15:8], 16'h0, ST_OK, 4'd0, 1'b0, 1'b0);
    endfunction

    function automatic void restart_rx();
        m_rx_crc = CRC_INIT;
        m_rx_count = 0;
        m_last_two = 16'h0;
        m_held = 8'h0;
        m_first_err = ST_OK;
    endfunction

    function automatic void note_error(logic [2:0] e);
        if (m_first_err == ST_OK) m_first_err = e;
    endfunction

    function automatic void reset_engine_state();
        m_limit = RETRY_RESET;
        m_tx_crc = CRC_INIT;
        m_func = F_RD_COILS;
        m_slave = 8'h0;
        m_addr = 16'h0;
        m_count = 16'h0;
        m_words_left = 7'd0;
        m_fails = 4'd0;
        restart_rx();
    endfunction

    // Echo check of one received byte against the request it answers.
    function automatic void check_echo(int p, logic [7:0] b);
        int exp_count;
        logic [7:0] exp_b;
        logic [2:0] err;
        if (m_func == F_RD_COILS || m_func == F_RD_COIL ||
            m_func == F_RD_HOLD || m_func == F_RD_INP) begin
            if (p == 2) begin
                exp_count = (m_func == F_RD_COILS) ? coil_bytes_due() :
                            (m_func == F_RD_COIL) ? 1 : 2 * int'(m_count);
                if (int'(b) != exp_count) note_error(ST_BCOUNT);
            end
            return;
        end
        case (p)
            0: begin exp_b = m_slave; err = ST_HEADER; end
            1: begin exp_b = code_of(m_func); err = ST_HEADER; end
            2: begin exp_b = m_addr[15:8]; err = ST_ADDR; end
            3: begin exp_b = m_addr[7:0]; err = ST_ADDR; end
            4: begin
                exp_b = (m_func == F_WR_COIL) ? ((m_count != 0) ? 8'hFF : 8'h00)
                                              : m_count[15:8];
                err = ST_VALUE;
            end
            5: begin
                exp_b = (m_func == F_WR_COIL) ? 8'h00 : m_count[7:0];
                err = ST_VALUE;
            end
            default: return;
        endcase
        if (b != exp_b) note_error(err);
    endfunction

    // Works out the results that one accepted transfer causes and queues them.
    function automatic void predict_engine(in_item_t it);
        logic [2:0]  f;
        logic [15:0] c;
        logic [7:0]  b;
        logic [2:0]  st;
        logic        give;
        int          p;
        int          minlen;
        step_results = {};
        case (it.cmd)
            CMD_REQ: begin
                if (it.func_sel != F_NONE) begin
                    f = it.func_sel;
                    c = it.count_or_value;
                    if (f == F_RD_COIL) c = 16'd1;
                    if (f == F_WR_MULTI && c > MAX_WRITE_WORDS) c = 16'(MAX_WRITE_WORDS);
                    // A different request starts its retry count afresh.
                    if (f != m_func || it.slave != m_slave || it.start_addr != m_addr ||
                        c != m_count) m_fails = 4'd0;
                    m_func = f;
                    m_slave = it.slave;
                    m_addr = it.start_addr;
                    m_count = c;
                    restart_rx();
                    m_tx_crc = CRC_INIT;
                    emit_tx(it.slave);
                    emit_tx(code_of(f));
                    emit_tx(it.start_addr[15:8]);
                    emit_tx(it.start_addr[7:0]);
                    if (f == F_WR_COIL) begin
                        emit_tx((c != 0) ? 8'hFF : 8'h00);
                        emit_tx(8'h00);
                    end else begin
                        emit_tx(c[15:8]);
                        emit_tx(c[7:0]);
                    end
                    if (f == F_WR_MULTI) begin
                        emit_tx({c[6:0], 1'b0});
                        m_words_left = c[6:0];
                        if (m_words_left == 0) emit_tx_crc();
                    end else begin
                        m_words_left = 7'd0;
                        emit_tx_crc();
                    end
                end
            end
            CMD_WORD: begin
                if (m_words_left != 0) begin
                    emit_tx(it.load_word[15:8]);
                    emit_tx(it.load_word[7:0]);
                    m_words_left = m_words_left - 7'd1;
                    if (m_words_left == 0) emit_tx_crc();
                end
            end
            CMD_RX: begin
                b = it.rx_byte;
                f = m_func;
                if (m_rx_count < RX_CAP) begin
                    p = m_rx_count;
                    // The CRC trails by two bytes so that the frame's own CRC
                    // never enters the sum.
                    if (p >= 2) m_rx_crc = crc_byte(m_rx_crc, m_last_two[15:8]);
                    m_last_two = {m_last_two[7:0], b};
                    check_echo(p, b);
                    if (f == F_RD_COILS) begin
                        if (p >= 3 && p - 3 < coil_bytes_due())
                            emit(K_DATA, 8'h0, {8'h00, b}, ST_OK, 4'd0, 1'b0, 1'b0);
                    end else if (f == F_RD_COIL) begin
                        if (p == 3) begin
                            m_held = b;
                            emit(K_DATA, 8'h0, {8'h00, b}, ST_OK, 4'd0, 1'b0, b != 0);
                        end
                    end else if (f == F_RD_HOLD || f == F_RD_INP) begin
                        if (p >= 3 && p - 3 < 2 * int'(m_count)) begin
                            if (((p - 3) & 1) == 0) m_held = b;
                            else emit(K_DATA, 8'h0, {m_held, b}, ST_OK, 4'd0, 1'b0, 1'b0);
                        end
                    end
                    m_rx_count = p + 1;
                end
                if (it.rx_last) begin
                    minlen = (f == F_WR_COIL || f == F_RD_HOLD || f == F_RD_INP ||
                              f == F_WR_REG) ? 8 : 6;
                    give = 1'b0;
                    if (m_rx_count < minlen) st = ST_SHORT;
                    else if (m_rx_crc[7:0] != m_last_two[15:8] ||
                             m_rx_crc[15:8] != m_last_two[7:0]) st = ST_CRC;
                    else st = m_first_err;
                    if (st != ST_OK) begin
                        if (m_fails != 4'd15) m_fails = m_fails + 4'd1;
                        give = (m_fails >= m_limit);
                    end
                    emit(K_STATUS, 8'h0, 16'h0, st, m_fails, give,
                         f == F_RD_COIL && st == ST_OK && m_held != 0);
                    if (st == ST_OK || give) m_fails = 4'd0;
                    restart_rx();
                end
            end
            default: ;
        endcase
        if (step_results.size() > 0) step_results[$].last = 1'b1;
        foreach (step_results[i]) results_due.push_back(step_results[i]);
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            mismatches++;
            if (mismatches <= 60)
                $display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Result checker: every accepted result is matched against the oldest
    // outstanding prediction, field by field.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 60)
                    $display("%0t: no result expected, actual %h", $time, m_data);
            end else begin
                want = results_due.pop_front();
                check_field("kind", int'(want.kind), int'(m_data.kind));
                check_field("tx_byte", int'(want.tx_byte), int'(m_data.tx_byte));
                check_field("rx_data", int'(want.rx_data), int'(m_data.rx_data));
                check_field("status", int'(want.status), int'(m_data.status));
                check_field("attempt", int'(want.attempt), int'(m_data.attempt));
                check_field("give_up", int'(want.give_up), int'(m_data.give_up));
                check_field("coil_on", int'(want.coil_on), int'(m_data.coil_on));
                check_field("last", int'(want.last), int'(m_data.last));
            end
        end
    end

    // Receiver: stretches of steady readiness, random stalls and sparse
    // readiness, plus a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (hold_served != hold_asked) begin
            hold_left = LONG_HOLD;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_style = $urandom_range(0, 2);
                stall_span = $urandom_range(20, 120);
            end
            stall_span--;
            case (stall_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t random_item();
        in_item_t    it;
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        it = r[$bits(in_item_t)-1:0];
        return it;
    endfunction

    // Offers one transfer, in bursts with random gaps, and waits until the
    // engine accepts it. Valid stays high afterwards so bursts run back to back.
    task automatic offer(input in_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        predict_engine(it);
    endtask

    task automatic send_request(input logic [2:0] f, input logic [7:0] sl,
                                input logic [15:0] ad, input logic [15:0] cv);
        in_item_t it;
        it = random_item();
        it.cmd = CMD_REQ;
        it.func_sel = f;
        it.slave = sl;
        it.start_addr = ad;
        it.count_or_value = cv;
        offer(it);
    endtask

    task automatic send_word(input logic [15:0] w);
        in_item_t it;
        it = random_item();
        it.cmd = CMD_WORD;
        it.load_word = w;
        offer(it);
    endtask

    task automatic send_rx(input logic [7:0] b, input logic fin);
        in_item_t it;
        it = random_item();
        it.cmd = CMD_RX;
        it.rx_byte = b;
        it.rx_last = fin;
        offer(it);
    endtask

    // One request, its data words, and a response that is well formed unless
    // a fault is asked for: 1 corrupts a byte, 2 cuts the frame short,
    // 3 appends a stray byte.
    task automatic exchange(input logic [2:0] f, input logic [7:0] sl,
                            input logic [15:0] ad, input logic [15:0] cv, input int fault);
        logic [15:0] c;
        logic [15:0] crc;
        logic [7:0]  frame[$];
        int          n;
        int          idx;
        send_request(f, sl, ad, cv);
        c = cv;
        if (f == F_RD_COIL) c = 16'd1;
        if (f == F_WR_MULTI && c > MAX_WRITE_WORDS) c = 16'(MAX_WRITE_WORDS);
        if (f == F_WR_MULTI) begin
            for (int k = 0; k < int'(c); k++) send_word(16'($urandom()));
        end
        frame = {sl, code_of(f)};
        case (f)
            F_RD_COILS: begin
                n = (int'(c) + 7) / 8;
                frame.push_back(n[7:0]);
                for (int k = 0; k < ((n < 12) ? n : 12); k++)
                    frame.push_back(8'($urandom()));
            end
            F_RD_COIL: begin
                frame.push_back(8'd1);
                frame.push_back(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom()));
            end
            F_RD_HOLD, F_RD_INP: begin
                frame.push_back({c[6:0], 1'b0});
                for (int k = 0; k < 2 * ((c < 10) ? int'(c) : 10); k++)
                    frame.push_back(8'($urandom()));
            end
            default: begin
                frame.push_back(ad[15:8]);
                frame.push_back(ad[7:0]);
                if (f == F_WR_COIL) begin
                    frame.push_back((cv != 0) ? 8'hFF : 8'h00);
                    frame.push_back(8'h00);
                end else begin
                    frame.push_back(c[15:8]);
                    frame.push_back(c[7:0]);
                end
            end
        endcase
        crc = CRC_INIT;
        foreach (frame[i]) crc = crc_byte(crc, frame[i]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        case (fault)
            1: begin
                idx = $urandom_range(0, frame.size() - 1);
                frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
            end
            2: frame = frame[0:$urandom_range(0, frame.size() - 2)];
            3: frame.push_back(8'($urandom()));
            default: ;
        endcase
        foreach (frame[i]) send_rx(frame[i], i == frame.size() - 1);
    endtask

    function automatic int pick_fault();
        int r;
        r = $urandom_range(0, 9);
        return (r < 6) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
    endfunction

    // Lowers valid and lets the engine settle so that the retry limit can be
    // written with nothing in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_retry_limit(input logic [3:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        m_limit = v;
    endtask

    // Field extremes, every function, the ignored transfers and frames that
    // arrive before any request.
    task automatic test_directed();
        in_item_t it;
        send_rx(8'hFF, 1'b0);
        send_rx(8'h00, 1'b0);
        send_rx(8'h5A, 1'b1);
        send_request(F_RD_COILS, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_request(F_RD_COILS, 8'h00, 16'h0000, 16'h0000);
        send_request(F_WR_COIL, 8'h11, 16'h1234, 16'h0000);
        send_request(F_WR_COIL, 8'h11, 16'h1234, 16'hFFFF);
        send_request(F_RD_HOLD, 8'h01, 16'h0000, 16'hFFFF);
        send_request(F_RD_INP, 8'h80, 16'h8000, 16'h0001);
        send_request(F_WR_REG, 8'h7F, 16'h00FF, 16'hFFFF);
        // Over-long multi-write: the count is clipped, then abandoned.
        send_request(F_WR_MULTI, 8'h02, 16'h0010, 16'hFFFF);
        // Zero-count multi-write closes with the CRC at once; words then
        // arrive with none awaited and are dropped.
        send_request(F_WR_MULTI, 8'h02, 16'h0010, 16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        it = random_item();
        it.cmd = CMD_REQ;
        it.func_sel = F_NONE;
        offer(it);
        it = random_item();
        it.cmd = 2'd3;
        offer(it);
        exchange(F_RD_COIL, 8'h05, 16'h0007, 16'h0000, 0);
    endtask

    // A request failing over and over until the engine gives up, at a limit
    // of one and at a limit of three.
    task automatic test_retry_limits();
        logic [3:0] lims[2];
        lims = '{4'd1, 4'd3};
        foreach (lims[i]) begin
            write_retry_limit(lims[i]);
            for (int k = 0; k <= int'(lims[i]); k++)
                exchange(F_RD_COIL, 8'h09, 16'h0100, 16'h0001, 1 + (k % 2));
            exchange(F_WR_REG, 8'h09, 16'h0100, 16'h00AA, 1);
            exchange(F_WR_REG, 8'h09, 16'h0100, 16'h00AA, 0);
        end
    endtask

    // A frame longer than the receive store: the excess bytes are ignored
    // while the final byte still closes the frame.
    task automatic test_long_frame();
        send_request(F_RD_HOLD, 8'h21, 16'h0040, 16'h0002);
        for (int k = 0; k < RX_CAP + 4; k++) send_rx(8'($urandom()), k == RX_CAP + 3);
    endtask

    // The receiver holds off while a long multi-write keeps arriving, so the
    // engine fills and must stall its input.
    task automatic test_backpressure();
        hold_asked++;
        exchange(F_WR_MULTI, 8'h33, 16'h2000, 16'd16, 0);
    endtask

    task automatic test_random();
        in_item_t it;
        logic [2:0] f;
        logic [15:0] cv;
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                it = random_item();
                offer(it);
            end else begin
                f = 3'($urandom_range(0, 6));
                case (f)
                    F_RD_COILS:          cv = 16'($urandom_range(0, 40));
                    F_RD_HOLD, F_RD_INP: cv = 16'($urandom_range(0, 10));
                    F_WR_MULTI:          cv = 16'($urandom_range(0, 6));
                    default:             cv = 16'($urandom());
                endcase
                if ($urandom_range(0, 40) == 0) cv = 16'($urandom());
                exchange(f, 8'($urandom()), 16'($urandom()), cv, pick_fault());
            end
        end
    endtask

    initial begin
        reset_engine_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_retry_limits();
        test_long_frame();
        test_backpressure();
        write_retry_limit(4'd10);
        test_random();
        write_retry_limit(4'd2);
        test_random();
        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mbm_pkg.sv
design/mbm_front.sv
design/mbm_back.sv
design/modbus_rtu_master_frame_engine.sv
test/tb_top.sv
